// File: hw/rtl/image_frame_deframer_assert.svh
// assertion macros shared by the deframer modules
`ifndef IMAGE_FRAME_DEFRAMER_ASSERT_SVH
`define IMAGE_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define IFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define IFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ifd_pkg.sv
`default_nettype none
package ifd_pkg;

  localparam int unsigned CNT_W = 25;

  localparam logic [CNT_W-1:0] MAX_RESET  = 25'd16777224;
  localparam logic [CNT_W-1:0] PRE_LEN    = 25'd6;
  localparam logic [CNT_W-1:0] LEN_END    = 25'd9;
  localparam logic [CNT_W-1:0] SEC_FIRST  = 25'd10;
  localparam logic [CNT_W-1:0] SEC_LAST   = 25'd13;
  localparam logic [CNT_W-1:0] NS_FIRST   = 25'd14;
  localparam logic [CNT_W-1:0] NS_LAST    = 25'd17;
  localparam logic [CNT_W-1:0] W_FIRST    = 25'd18;
  localparam logic [CNT_W-1:0] W_LAST     = 25'd19;
  localparam logic [CNT_W-1:0] H_FIRST    = 25'd20;
  localparam logic [CNT_W-1:0] H_LAST     = 25'd21;
  localparam logic [CNT_W-1:0] HDR_END    = 25'd22;
  localparam logic [CNT_W-1:0] OVERHEAD   = 25'd28;
  localparam logic [CNT_W:0]   TAIL_LEN   = 26'd6;

  localparam logic [7:0] PREAMBLE [0:5] = '{8'hFE, 8'hCA, 8'h00, 8'hFF, 8'h00, 8'hFF};
  localparam logic [39:0] TAIL_HEAD = 40'hCC_FE_FF_00_FF;
  localparam logic [7:0]  TAIL_LAST = 8'h00;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_MISMATCH = 3'd3,
    KIND_DROP     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PAYLOAD,
    OP_SEC,
    OP_NS,
    OP_WIDTH,
    OP_HEIGHT,
    OP_STEP,
    OP_END,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        len_ok;
    logic [23:0] target;
  } token_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_byte;
    logic [31:0] seconds;
    logic [31:0] nanos;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  step;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/ifd_fifo.sv
`default_nettype none
`include "image_frame_deframer_assert.svh"
module ifd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr;
  logic             rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `IFD_ASSERT_NEXT(a_fifo_fill, wr && !rd, count == $past(count) + 1'b1, "fifo fill count lost a write")
  `IFD_ASSERT_SAME(a_fifo_ptrs, empty || full, wr_ptr == rd_ptr, "fifo pointers disagree with count")

endmodule
`default_nettype wire

// File: hw/rtl/ifd_front.sv
`default_nettype none
`include "image_frame_deframer_assert.svh"
module ifd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [24:0]          cfg_data,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  output ifd_pkg::token_t      tok
);

  logic [24:0] count;
  logic [24:0] count_next;
  logic [24:0] fl;
  logic [24:0] fl_next;
  logic [24:0] max_bytes;
  logic [39:0] recent;
  logic [39:0] recent_next;
  logic [24:0] n;
  logic [24:0] diff;
  logic        is_tail;
  logic        drop;
  logic        done_frame;
  ifd_pkg::op_t op;

  assign n       = count + 25'd1;
  assign is_tail = (recent == ifd_pkg::TAIL_HEAD) && (in_byte == ifd_pkg::TAIL_LAST);
  assign diff    = fl_next - ifd_pkg::OVERHEAD;

  always_comb begin
    count_next  = count;
    recent_next = recent;
    fl_next     = fl;
    drop        = 1'b0;
    done_frame  = 1'b0;
    op          = ifd_pkg::OP_NONE;
    if (count < ifd_pkg::PRE_LEN) begin
      // preamble hunt
      if (in_byte == ifd_pkg::PREAMBLE[count[2:0]]) begin
        count_next  = n;
        recent_next = {recent[31:0], in_byte};
      end else begin
        count_next = '0;
      end
    end else begin
      if (n == ifd_pkg::LEN_END) begin
        fl_next = {1'b0, recent[15:0], in_byte} + ifd_pkg::LEN_END;
      end
      recent_next = {recent[31:0], in_byte};
      count_next  = n;
      drop        = (is_tail && (n != fl_next)) || (n >= max_bytes);
      done_frame  = (n >= ifd_pkg::LEN_END) && (n >= fl_next);
      priority if (drop) begin
        count_next = '0;
        op         = ifd_pkg::OP_DROP;
      end else if (done_frame) begin
        count_next = '0;
        op         = ifd_pkg::OP_END;
      end else if (n >= ifd_pkg::SEC_FIRST && n <= ifd_pkg::SEC_LAST) begin
        op = ifd_pkg::OP_SEC;
      end else if (n >= ifd_pkg::NS_FIRST && n <= ifd_pkg::NS_LAST) begin
        op = ifd_pkg::OP_NS;
      end else if (n >= ifd_pkg::W_FIRST && n <= ifd_pkg::W_LAST) begin
        op = ifd_pkg::OP_WIDTH;
      end else if (n >= ifd_pkg::H_FIRST && n <= ifd_pkg::H_LAST) begin
        op = ifd_pkg::OP_HEIGHT;
      end else if (n == ifd_pkg::HDR_END) begin
        op = ifd_pkg::OP_STEP;
      end else if (n > ifd_pkg::HDR_END &&
                   ({1'b0, n} + ifd_pkg::TAIL_LEN) <= {1'b0, fl_next}) begin
        op = ifd_pkg::OP_PAYLOAD;
      end
    end
  end

  always_comb begin
    tok.op     = op;
    tok.data   = in_byte;
    tok.len_ok = (fl_next >= ifd_pkg::OVERHEAD);
    tok.target = diff[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fl        <= '0;
      recent    <= '0;
      max_bytes <= ifd_pkg::MAX_RESET;
    end else begin
      if (accept) begin
        count  <= count_next;
        fl     <= fl_next;
        recent <= recent_next;
      end
      if (cfg_we) begin
        max_bytes <= cfg_data;
      end
    end
  end

  `IFD_ASSERT_NEXT(a_front_restart, accept && (op == ifd_pkg::OP_DROP || op == ifd_pkg::OP_END), count == '0, "frame end did not restart the hunt")

endmodule
`default_nettype wire

// File: hw/rtl/ifd_back.sv
`default_nettype none
`include "image_frame_deframer_assert.svh"
module ifd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tok_valid,
  input  ifd_pkg::token_t      tok,
  output logic                 tok_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output ifd_pkg::result_t     res
);

  logic [31:0] hdr_seconds;
  logic [31:0] hdr_nanos;
  logic [15:0] hdr_width;
  logic [15:0] hdr_height;
  logic [7:0]  hdr_step;
  logic [31:0] wh;
  logic [39:0] prod;
  logic        take;
  logic        size_ok;

  assign take     = tok_valid && !res_full;
  assign tok_pop  = take;
  assign res_push = take;
  assign size_ok  = tok.len_ok && (prod == {16'b0, tok.target});

  // product is registered in two multiply steps, wh then prod, and settles well before the frame can end
  always_ff @(posedge clk) begin
    wh   <= hdr_width * hdr_height;
    prod <= wh * hdr_step;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      unique case (tok.op)
        ifd_pkg::OP_SEC:    hdr_seconds <= {hdr_seconds[23:0], tok.data};
        ifd_pkg::OP_NS:     hdr_nanos   <= {hdr_nanos[23:0], tok.data};
        ifd_pkg::OP_WIDTH:  hdr_width   <= {hdr_width[7:0], tok.data};
        ifd_pkg::OP_HEIGHT: hdr_height  <= {hdr_height[7:0], tok.data};
        ifd_pkg::OP_STEP:   hdr_step    <= tok.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res      = '0;
    res.kind = ifd_pkg::KIND_NONE;
    unique case (tok.op)
      ifd_pkg::OP_PAYLOAD: begin
        res.kind       = ifd_pkg::KIND_PAYLOAD;
        res.pixel_byte = tok.data;
      end
      ifd_pkg::OP_DROP: begin
        res.kind = ifd_pkg::KIND_DROP;
      end
      ifd_pkg::OP_END: begin
        if (size_ok) begin
          res.kind    = ifd_pkg::KIND_GOOD;
          res.seconds = hdr_seconds;
          res.nanos   = hdr_nanos;
          res.width   = hdr_width;
          res.height  = hdr_height;
          res.step    = hdr_step;
        end else begin
          res.kind = ifd_pkg::KIND_MISMATCH;
        end
      end
      default: begin
        res.kind = ifd_pkg::KIND_NONE;
      end
    endcase
  end

  `IFD_ASSERT_SAME(a_back_short, take && tok.op == ifd_pkg::OP_END && !tok.len_ok, res.kind == ifd_pkg::KIND_MISMATCH, "short frame reported good")

endmodule
`default_nettype wire

// File: hw/rtl/image_frame_deframer.sv
// image_frame_deframer: byte-stream frame parser
// input side is a queue: a byte transfers on a clock edge with push high and
//   full low; a new byte can transfer on every cycle
// result side is a queue: the oldest result sits on kind and the field ports
//   while empty is low and transfers on an edge with pop high
// every byte in gives exactly one result: nothing, a payload byte, a good
//   frame with its header, a size mismatch, or a dropped frame
// a byte's token is written into the token queue at its transfer, and its
//   result is written into the result queue when the report stage takes it
// throughput: one byte per cycle while full is low, set by the single-token
//   step of the parser and of the report stage
// the parser and the report stage are split by a token queue; the header
//   product is computed in two registered multiply steps while the image
//   bytes stream
// when pop is held low results collect in the output queue, then the token
//   queue fills and full rises until results drain
// cfg_we writes cfg_data into the frame size limit
// rst (synchronous) empties both queues, restarts the preamble hunt and sets
//   the limit to 16777224
`default_nettype none
module image_frame_deframer #(
  parameter int unsigned TOK_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [24:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  kind,
  output logic [7:0]  pixel_byte,
  output logic [31:0] stamp_seconds,
  output logic [31:0] stamp_nanos,
  output logic [15:0] img_width,
  output logic [15:0] img_height,
  output logic [7:0]  bytes_per_pixel
);

  ifd_pkg::token_t  tok_in;
  ifd_pkg::token_t  tok_out;
  ifd_pkg::result_t res_in;
  ifd_pkg::result_t res_out;
  logic             accept;
  logic             tok_empty;
  logic             tok_pop;
  logic             res_full;
  logic             res_push;

  assign accept = push && !full;

  ifd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .tok      (tok_in)
  );

  ifd_fifo #(
    .WIDTH ($bits(ifd_pkg::token_t)),
    .DEPTH (TOK_DEPTH)
  ) u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (tok_in),
    .full    (full),
    .rd_en   (tok_pop),
    .rd_data (tok_out),
    .empty   (tok_empty)
  );

  ifd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!tok_empty),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ifd_fifo #(
    .WIDTH ($bits(ifd_pkg::result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign kind            = res_out.kind;
  assign pixel_byte      = res_out.pixel_byte;
  assign stamp_seconds   = res_out.seconds;
  assign stamp_nanos     = res_out.nanos;
  assign img_width       = res_out.width;
  assign img_height      = res_out.height;
  assign bytes_per_pixel = res_out.step;

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  class deframer_scoreboard;
    logic [ifd_pkg::CNT_W-1:0] limit;
    logic [ifd_pkg::CNT_W-1:0] cnt;
    logic [ifd_pkg::CNT_W-1:0] flen;
    logic [39:0]               recent;
    logic [31:0]               sec;
    logic [31:0]               nano;
    logic [15:0]               wid;
    logic [15:0]               hgt;
    logic [7:0]                stp;
    ifd_pkg::result_t          pending_results[$];
    int                        errors;
    int                        n_bytes;
    int                        n_checked;
    int                        n_good;
    int                        n_mismatch;
    int                        n_drop;
    int                        n_payload;

    function new();
      limit = ifd_pkg::MAX_RESET;
      cnt = '0;
      flen = '0;
      recent = '0;
      sec = '0;
      nano = '0;
      wid = '0;
      hgt = '0;
      stp = '0;
    endfunction

    function int frames();
      return n_good + n_mismatch + n_drop;
    endfunction

    // next-state and expected result for one byte transfer
    function void note_byte(logic [7:0] b);
      ifd_pkg::result_t          r;
      logic [ifd_pkg::CNT_W-1:0] n;
      logic                      tail_hit;
      logic [39:0]               prod;
      r = '0;
      r.kind = ifd_pkg::KIND_NONE;
      n_bytes++;
      if (cnt < ifd_pkg::PRE_LEN) begin
        if (b != ifd_pkg::PREAMBLE[cnt[2:0]]) begin
          cnt = '0;
        end else begin
          cnt = cnt + 1'b1;
          recent = {recent[31:0], b};
        end
      end else begin
        n = cnt + 1'b1;
        if (n == ifd_pkg::LEN_END) flen = {1'b0, recent[15:0], b} + ifd_pkg::LEN_END;
        if (n >= ifd_pkg::SEC_FIRST && n <= ifd_pkg::SEC_LAST) sec = {sec[23:0], b};
        else if (n >= ifd_pkg::NS_FIRST && n <= ifd_pkg::NS_LAST) nano = {nano[23:0], b};
        else if (n >= ifd_pkg::W_FIRST && n <= ifd_pkg::W_LAST) wid = {wid[7:0], b};
        else if (n >= ifd_pkg::H_FIRST && n <= ifd_pkg::H_LAST) hgt = {hgt[7:0], b};
        else if (n == ifd_pkg::HDR_END) stp = b;
        tail_hit = (recent == ifd_pkg::TAIL_HEAD) && (b == ifd_pkg::TAIL_LAST);
        recent = {recent[31:0], b};
        cnt = n;
        if ((tail_hit && n != flen) || n >= limit) begin
          cnt = '0;
          r.kind = ifd_pkg::KIND_DROP;
          n_drop++;
        end else if (n < ifd_pkg::LEN_END || n < flen) begin
          if (n > ifd_pkg::HDR_END &&
              {1'b0, n} + ifd_pkg::TAIL_LEN <= {1'b0, flen}) begin
            r.kind = ifd_pkg::KIND_PAYLOAD;
            r.pixel_byte = b;
            n_payload++;
          end
        end else begin
          cnt = '0;
          prod = 40'(wid) * 40'(hgt) * 40'(stp);
          if (flen >= ifd_pkg::OVERHEAD && prod == 40'(flen - ifd_pkg::OVERHEAD)) begin
            r.kind = ifd_pkg::KIND_GOOD;
            r.seconds = sec;
            r.nanos = nano;
            r.width = wid;
            r.height = hgt;
            r.step = stp;
            n_good++;
          end else begin
            r.kind = ifd_pkg::KIND_MISMATCH;
            n_mismatch++;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [39:0] got, logic [39:0] want);
      errors++;
      $display("mismatch at result %0d, %s: got %0h, want %0h", n_checked, what, got, want);
    endtask

    task check_result(ifd_pkg::result_t got);
      ifd_pkg::result_t want;
      n_checked++;
      if (pending_results.size() == 0) begin
        report("transfer with nothing outstanding, kind", 40'(got.kind), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report("kind", 40'(got.kind), 40'(want.kind));
      if (got.pixel_byte !== want.pixel_byte)
        report("pixel_byte", 40'(got.pixel_byte), 40'(want.pixel_byte));
      if (got.seconds !== want.seconds)
        report("stamp_seconds", 40'(got.seconds), 40'(want.seconds));
      if (got.nanos !== want.nanos)
        report("stamp_nanos", 40'(got.nanos), 40'(want.nanos));
      if (got.width !== want.width)
        report("img_width", 40'(got.width), 40'(want.width));
      if (got.height !== want.height)
        report("img_height", 40'(got.height), 40'(want.height));
      if (got.step !== want.step)
        report("bytes_per_pixel", 40'(got.step), 40'(want.step));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [24:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [2:0]  kind;
  logic [7:0]  pixel_byte;
  logic [31:0] stamp_seconds;
  logic [31:0] stamp_nanos;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic [7:0]  bytes_per_pixel;

  deframer_scoreboard sb;
  logic [7:0]         byte_q[$];
  ifd_pkg::result_t   out_seen;
  int                 send_gap;
  int                 pop_gap;
  bit                 in_calm;
  bit                 out_calm;

  image_frame_deframer u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .pop             (pop),
    .empty           (empty),
    .kind            (kind),
    .pixel_byte      (pixel_byte),
    .stamp_seconds   (stamp_seconds),
    .stamp_nanos     (stamp_nanos),
    .img_width       (img_width),
    .img_height      (img_height),
    .bytes_per_pixel (bytes_per_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void add_tail();
    int k;
    for (k = 4; k >= 0; k--) byte_q.push_back(ifd_pkg::TAIL_HEAD[8*k +: 8]);
    byte_q.push_back(ifd_pkg::TAIL_LAST);
  endfunction

  // frame from the given length and header fields; tail_at >= 0 puts an extra tail inside the image bytes
  function automatic void build_frame(input logic [23:0] len, input logic [31:0] sec,
                                      input logic [31:0] nano, input logic [15:0] w,
                                      input logic [15:0] h, input logic [7:0] s,
                                      input int plen, input int tail_at);
    int k;
    for (k = 0; k < 6; k++) byte_q.push_back(ifd_pkg::PREAMBLE[k]);
    for (k = 2; k >= 0; k--) byte_q.push_back(len[8*k +: 8]);
    for (k = 3; k >= 0; k--) byte_q.push_back(sec[8*k +: 8]);
    for (k = 3; k >= 0; k--) byte_q.push_back(nano[8*k +: 8]);
    byte_q.push_back(w[15:8]);
    byte_q.push_back(w[7:0]);
    byte_q.push_back(h[15:8]);
    byte_q.push_back(h[7:0]);
    byte_q.push_back(s);
    for (k = 0; k <= plen; k++) begin
      if (k == tail_at) add_tail();
      if (k < plen) byte_q.push_back(8'($urandom()));
    end
    add_tail();
  endfunction

  function automatic void add_frame();
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  s;
    logic [23:0] len;
    int          plen;
    int          pick;
    int          start;
    int          tail_at;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      w = 16'($urandom_range(0, 4));
      h = 16'($urandom_range(0, 4));
      s = 8'($urandom_range(0, 3));
    end else if (pick < 8) begin
      w = 16'($urandom());
      h = '0;
      s = 8'($urandom());
    end else begin
      w = 16'($urandom_range(0, 3));
      h = 16'($urandom());
      s = '0;
    end
    plen = int'(w) * int'(h) * int'(s);
    len = 24'(plen + 19);
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 24'($urandom_range(0, 18));
    else if (pick == 1) len = len + 24'($urandom_range(1, 3));
    else if (pick == 2) plen = plen + $urandom_range(1, 3);
    else if (pick == 3) s = s + 8'd1;
    if ($urandom_range(0, 9) == 0) tail_at = $urandom_range(0, plen);
    else tail_at = -1;
    start = byte_q.size();
    build_frame(len, $urandom(), $urandom(), w, h, s, plen, tail_at);
    pick = $urandom_range(0, 11);
    if (pick == 0) byte_q[$urandom_range(start, byte_q.size() - 1)] = 8'($urandom());
    else if (pick == 1) repeat ($urandom_range(1, 8)) void'(byte_q.pop_back());
  endfunction

  // line noise, often led by part of a preamble
  function automatic void add_noise();
    int k;
    int m;
    m = $urandom_range(0, 5);
    for (k = 0; k < m; k++) byte_q.push_back(ifd_pkg::PREAMBLE[k]);
    repeat ($urandom_range(1, 10)) byte_q.push_back(8'($urandom()));
  endfunction

  task automatic write_limit(input logic [24:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (byte_q.size() != 0 || push || sb.pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // input side: a byte transfers when push is high and full is low
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_byte(in_byte);
      if (!(push && full)) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (byte_q.size() != 0) begin
          push <= 1'b1;
          in_byte <= byte_q.pop_front();
          if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
          send_gap = pick_gap(in_calm);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side: a result transfers when pop is high and empty is low
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        out_seen.kind = ifd_pkg::kind_t'(kind);
        out_seen.pixel_byte = pixel_byte;
        out_seen.seconds = stamp_seconds;
        out_seen.nanos = stamp_nanos;
        out_seen.width = img_width;
        out_seen.height = img_height;
        out_seen.step = bytes_per_pixel;
        sb.check_result(out_seen);
        if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
        pop_gap = pick_gap(out_calm);
      end
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("image_frame_deframer regression: fail");
    $finish;
  end

  initial begin
    int          phase;
    logic [24:0] lim;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_limit(ifd_pkg::MAX_RESET);

    // partial preambles broken off, a repeated first byte
    byte_q.push_back(8'hFE);
    byte_q.push_back(8'hCA);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h11);
    byte_q.push_back(8'hFE);
    byte_q.push_back(8'hFE);
    byte_q.push_back(8'hCA);
    // empty image with extreme header values
    build_frame(24'd19, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 8'hFF, 0, -1);
    // zero length ends inside the length field
    build_frame(24'd0, 32'h1234_5678, 32'h9ABC_DEF0, 16'd1, 16'd1, 8'd1, 0, -1);
    build_frame(24'd20, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd1, 8'd1, 1, -1);
    // largest length, tail far too early
    build_frame(24'hFF_FFFF, $urandom(), $urandom(), 16'd2, 16'd2, 8'd2, 3, -1);
    build_frame(24'd25, $urandom(), $urandom(), 16'd2, 16'd2, 8'd2, 6, -1);
    build_frame(24'd26, $urandom(), $urandom(), 16'd1, 16'd7, 8'd1, 7, 2);
    // broken tail byte, frame still ends on count
    build_frame(24'd21, $urandom(), $urandom(), 16'd1, 16'd2, 8'd1, 2, -1);
    byte_q[byte_q.size() - 1] = 8'h5A;
    wait_idle();

    phase = 1;
    while (sb.n_bytes < 1000) begin
      if (phase == 1) lim = 25'd1;
      else if (phase == 2) lim = ifd_pkg::MAX_RESET;
      else begin
        case ($urandom_range(0, 5))
          0: lim = 25'd1;
          1: lim = ifd_pkg::MAX_RESET;
          2, 3: lim = 25'($urandom_range(7, 40));
          default: lim = 25'($urandom_range(41, 200));
        endcase
      end
      write_limit(lim);
      repeat ($urandom_range(4, 9)) begin
        if ($urandom_range(0, 4) == 0) add_noise();
        else add_frame();
      end
      wait_idle();
      phase++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report("results still outstanding", 40'(sb.pending_results.size()), '0);

    $display("covered %0d byte transfers under %0d limit settings, noise included",
             sb.n_bytes, phase);
    $display("%0d good frames, %0d size mismatches, %0d dropped, %0d image bytes",
             sb.n_good, sb.n_mismatch, sb.n_drop, sb.n_payload);
    if (sb.errors == 0) begin
      $display("image_frame_deframer regression: pass");
    end else begin
      $display("image_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
